// File: rtl/core/script_source_tokenizer_assert.svh
// assertion macros used by the checker file
`ifndef SCRIPT_SOURCE_TOKENIZER_ASSERT_SVH
`define SCRIPT_SOURCE_TOKENIZER_ASSERT_SVH

// same-cycle implication, sampled on the rising edge, quiet during reset
`define SST_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tokenizer check failed");

// next-cycle implication
`define SST_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tokenizer check failed");

`endif

// File: rtl/core/sst_pkg.sv
package sst_pkg;

	localparam int COUNT_WIDTH_DEF = 16;
	localparam int MAX_RES = 4;
	localparam int RES_IDX_W = 2;
	localparam int RES_CNT_W = 3;

	// result kinds
	localparam logic [1:0] KIND_TOK  = 2'd0;
	localparam logic [1:0] KIND_DONE = 2'd1;
	localparam logic [1:0] KIND_ERR  = 2'd2;

	// error codes
	localparam logic [1:0] ERR_BRACKET  = 2'd0;
	localparam logic [1:0] ERR_ESCAPE   = 2'd1;
	localparam logic [1:0] ERR_CHAR_LIT = 2'd2;
	localparam logic [1:0] ERR_STRING   = 2'd3;

	// characters with a meaning of their own
	localparam logic [7:0] CH_LBRACKET = 8'h5B;
	localparam logic [7:0] CH_RBRACKET = 8'h5D;
	localparam logic [7:0] CH_SLASH    = 8'h2F;
	localparam logic [7:0] CH_QUOTE    = 8'h27;
	localparam logic [7:0] CH_DQUOTE   = 8'h22;
	localparam logic [7:0] CH_BSLASH   = 8'h5C;
	localparam logic [7:0] CH_ZERO     = 8'h30;
	localparam logic [7:0] CH_N        = 8'h6E;
	localparam logic [7:0] CH_T        = 8'h74;
	localparam logic [7:0] CH_NEWLINE  = 8'h0A;
	localparam logic [7:0] CH_TAB      = 8'h09;
	localparam logic [7:0] CH_SPACE    = 8'h20;
	localparam logic [7:0] CH_CR       = 8'h0D;
	localparam logic [7:0] CH_NUL      = 8'h00;

	typedef struct packed {
		logic [7:0] ch;
		logic       at_end;
	} in_word_t;

	typedef struct packed {
		logic [1:0]  out_kind;
		logic [7:0]  tok_byte;
		logic        tok_last;
		logic [1:0]  err_code;
		logic [15:0] token_count;
	} out_word_t;

	// all the words one source byte gives rise to
	typedef struct packed {
		logic [RES_CNT_W-1:0]        n;
		out_word_t [MAX_RES-1:0]     res;
	} batch_t;

	function automatic out_word_t tok_word(input logic [7:0] b, input logic last);
		out_word_t w;
		w = '0;
		w.out_kind = KIND_TOK;
		w.tok_byte = b;
		w.tok_last = last;
		return w;
	endfunction

endpackage

// File: rtl/core/sst_front.sv
module sst_front import sst_pkg::*; #(
	parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  in_word_t item,
	output logic     full,
	input  logic     q_room,
	output logic     b_push,
	output batch_t   b_data
);

	localparam logic [3:0] M_NORMAL  = 4'd0;
	localparam logic [3:0] M_LINE    = 4'd1;
	localparam logic [3:0] M_BRACKET = 4'd2;
	localparam logic [3:0] M_LIT0    = 4'd3;
	localparam logic [3:0] M_LIT1    = 4'd4;
	localparam logic [3:0] M_LIT2    = 4'd5;
	localparam logic [3:0] M_STR     = 4'd6;
	localparam logic [3:0] M_STRESC  = 4'd7;
	localparam logic [3:0] M_DEAD    = 4'd8;

	localparam int EXT_W = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;
	localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

	logic [3:0]             mode_q, md;
	logic [7:0]             held_q, hb;
	logic                   hv_q, hv;
	logic                   sw_q, sw;
	logic [7:0]             lf_q, lf;
	logic [7:0]             ls_q, ls;
	logic                   open_q, to;
	logic [COUNT_WIDTH-1:0] seen_q, ts;

	logic                 acc;
	logic [RES_CNT_W-1:0] n;
	out_word_t [MAX_RES-1:0] r;
	logic                 do_byte, do_end, skip, lone;
	logic [8:0]           esc;
	logic [EXT_W-1:0]     ts_ext;
	logic [7:0]           b;

	// {ok, value}
	function automatic logic [8:0] unescape(input logic [7:0] c, input logic [7:0] quote);
		logic [8:0] v;
		v = '0;
		if (c == CH_N)
			v = {1'b1, CH_NEWLINE};
		else if (c == CH_T)
			v = {1'b1, CH_TAB};
		else if (c == CH_ZERO)
			v = {1'b1, CH_NUL};
		else if (c == CH_BSLASH)
			v = {1'b1, CH_BSLASH};
		else if (c == quote)
			v = {1'b1, quote};
		return v;
	endfunction

	assign full = !q_room;
	assign acc  = push && q_room;
	assign b    = item.ch;

	always_comb begin
		md = mode_q; hb = held_q; hv = hv_q; sw = sw_q;
		lf = lf_q; ls = ls_q; to = open_q; ts = seen_q;
		n = '0; r = '0;
		do_byte = 1'b0; do_end = 1'b0; skip = 1'b0; lone = 1'b0;
		esc = '0; ts_ext = '0;
		unique case (mode_q)
			M_NORMAL: begin
				if (item.at_end)
					do_end = 1'b1;
				else
					do_byte = 1'b1;
			end
			M_LINE: begin
				if (item.at_end)
					do_end = 1'b1;
				else if (b == CH_NEWLINE)
					md = M_NORMAL;
			end
			M_BRACKET: begin
				if (item.at_end) begin
					r[n[RES_IDX_W-1:0]] = '{KIND_ERR, 8'h00, 1'b0, ERR_BRACKET, 16'h0000};
					n = n + 1'b1; md = M_DEAD;
				end else if (b == CH_RBRACKET) begin
					md = M_NORMAL;
				end
			end
			M_LIT0: begin
				if (item.at_end) begin
					r[n[RES_IDX_W-1:0]] = '{KIND_ERR, 8'h00, 1'b0, ERR_CHAR_LIT, 16'h0000};
					n = n + 1'b1; md = M_DEAD;
				end else begin
					lf = b; md = M_LIT1;
				end
			end
			M_LIT1: begin
				if (item.at_end || (lf_q != CH_BSLASH && b != CH_QUOTE)) begin
					r[n[RES_IDX_W-1:0]] = '{KIND_ERR, 8'h00, 1'b0, ERR_CHAR_LIT, 16'h0000};
					n = n + 1'b1; md = M_DEAD;
				end else if (lf_q == CH_BSLASH) begin
					ls = b; md = M_LIT2;
				end else begin
					r[0] = tok_word(CH_QUOTE, 1'b0);
					r[1] = tok_word(lf_q, 1'b0);
					r[2] = tok_word(CH_QUOTE, 1'b1);
					n = 3'd3;
					if (ts != COUNT_MAX) ts = ts + 1'b1;
					md = M_NORMAL;
				end
			end
			M_LIT2: begin
				esc = unescape(ls_q, CH_QUOTE);
				if (!item.at_end && b == CH_QUOTE) begin
					if (esc[8]) begin
						r[0] = tok_word(CH_QUOTE, 1'b0);
						r[1] = tok_word(esc[7:0], 1'b0);
						r[2] = tok_word(CH_QUOTE, 1'b1);
						n = 3'd3;
						if (ts != COUNT_MAX) ts = ts + 1'b1;
						md = M_LIT0;
					end else begin
						r[0] = '{KIND_ERR, 8'h00, 1'b0, ERR_ESCAPE, 16'h0000};
						n = 3'd1; md = M_DEAD;
					end
				end else if (ls_q == CH_QUOTE) begin
					// lone backslash literal, the byte after it is fresh text
					r[0] = tok_word(CH_QUOTE, 1'b0);
					r[1] = tok_word(CH_BSLASH, 1'b0);
					r[2] = tok_word(CH_QUOTE, 1'b1);
					n = 3'd3;
					if (ts != COUNT_MAX) ts = ts + 1'b1;
					md = M_NORMAL;
					if (item.at_end)
						do_end = 1'b1;
					else
						do_byte = 1'b1;
				end else begin
					r[0] = '{KIND_ERR, 8'h00, 1'b0, ERR_CHAR_LIT, 16'h0000};
					n = 3'd1; md = M_DEAD;
				end
			end
			M_STR: begin
				if (item.at_end) begin
					r[0] = '{KIND_ERR, 8'h00, 1'b0, ERR_STRING, 16'h0000};
					n = 3'd1; md = M_DEAD;
				end else if (b == CH_DQUOTE) begin
					r[0] = tok_word(CH_ZERO, 1'b1);
					n = 3'd1;
					if (ts != COUNT_MAX) ts = ts + 1'b1;
					md = M_NORMAL;
				end else if (b == CH_BSLASH) begin
					md = M_STRESC;
				end else begin
					r[0] = tok_word(CH_QUOTE, 1'b0);
					r[1] = tok_word(b, 1'b0);
					r[2] = tok_word(CH_QUOTE, 1'b1);
					n = 3'd3;
					if (ts != COUNT_MAX) ts = ts + 1'b1;
				end
			end
			M_STRESC: begin
				esc = unescape(b, CH_DQUOTE);
				if (item.at_end) begin
					r[0] = '{KIND_ERR, 8'h00, 1'b0, ERR_STRING, 16'h0000};
					n = 3'd1; md = M_DEAD;
				end else if (esc[8]) begin
					r[0] = tok_word(CH_QUOTE, 1'b0);
					r[1] = tok_word(esc[7:0], 1'b0);
					r[2] = tok_word(CH_QUOTE, 1'b1);
					n = 3'd3;
					if (ts != COUNT_MAX) ts = ts + 1'b1;
					md = M_STR;
				end else begin
					r[0] = '{KIND_ERR, 8'h00, 1'b0, ERR_ESCAPE, 16'h0000};
					n = 3'd1; md = M_DEAD;
				end
			end
			default: begin
				// dead after an error, the end marker restarts
				if (item.at_end) begin
					md = M_NORMAL; hb = '0; hv = 1'b0; sw = 1'b0;
					lf = '0; ls = '0; to = 1'b0; ts = '0;
				end
			end
		endcase

		if (do_byte) begin
			if (sw) begin
				sw = 1'b0;
				if (b == CH_SLASH) begin
					if (hv) begin
						r[n[RES_IDX_W-1:0]] = tok_word(hb, 1'b1);
						n = n + 1'b1;
						if (ts != COUNT_MAX) ts = ts + 1'b1;
					end
					hv = 1'b0; to = 1'b0; md = M_LINE; skip = 1'b1;
				end else begin
					if (hv) begin
						r[n[RES_IDX_W-1:0]] = tok_word(hb, 1'b0);
						n = n + 1'b1; to = 1'b1;
					end
					hb = CH_SLASH; hv = 1'b1;
				end
			end
			if (!skip) begin
				if (b == CH_SPACE || (b >= CH_TAB && b <= CH_CR) || b == CH_LBRACKET
						|| b == CH_QUOTE || b == CH_DQUOTE) begin
					if (hv) begin
						r[n[RES_IDX_W-1:0]] = tok_word(hb, 1'b1);
						n = n + 1'b1;
						if (ts != COUNT_MAX) ts = ts + 1'b1;
					end
					hv = 1'b0; to = 1'b0;
					if (b == CH_LBRACKET)
						md = M_BRACKET;
					else if (b == CH_QUOTE)
						md = M_LIT0;
					else if (b == CH_DQUOTE)
						md = M_STR;
				end else if (b == CH_SLASH) begin
					sw = 1'b1;
				end else begin
					if (hv) begin
						r[n[RES_IDX_W-1:0]] = tok_word(hb, 1'b0);
						n = n + 1'b1; to = 1'b1;
					end
					hb = b; hv = 1'b1;
				end
			end
		end

		if (do_end) begin
			// in line-comment mode nothing is held, so this only finishes
			lone = !to && (hv ^ sw);
			if (!lone) begin
				if (hv) begin
					r[n[RES_IDX_W-1:0]] = tok_word(hb, !sw);
					n = n + 1'b1;
					if (!sw && ts != COUNT_MAX) ts = ts + 1'b1;
				end
				if (sw) begin
					r[n[RES_IDX_W-1:0]] = tok_word(CH_SLASH, 1'b1);
					n = n + 1'b1;
					if (ts != COUNT_MAX) ts = ts + 1'b1;
				end
			end
			ts_ext = EXT_W'(ts);
			r[n[RES_IDX_W-1:0]] = '{KIND_DONE, 8'h00, 1'b0, 2'd0,
				(ts_ext > EXT_W'(16'hFFFF)) ? 16'hFFFF : ts_ext[15:0]};
			n = n + 1'b1;
			md = M_NORMAL; hb = '0; hv = 1'b0; sw = 1'b0;
			lf = '0; ls = '0; to = 1'b0; ts = '0;
		end
	end

	assign b_push = acc && (n != '0);
	assign b_data = '{n, r};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_NORMAL;
			held_q <= '0;
			hv_q   <= 1'b0;
			sw_q   <= 1'b0;
			lf_q   <= '0;
			ls_q   <= '0;
			open_q <= 1'b0;
			seen_q <= '0;
		end else if (acc) begin
			mode_q <= md;
			held_q <= hb;
			hv_q   <= hv;
			sw_q   <= sw;
			lf_q   <= lf;
			ls_q   <= ls;
			open_q <= to;
			seen_q <= ts;
		end
	end

endmodule

// File: rtl/core/sst_queue.sv
module sst_queue import sst_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   wr,
	input  batch_t wdata,
	output logic   room,
	output logic   head_valid,
	output batch_t head,
	input  logic   rd
);

	batch_t     mem_q [2];
	logic       wptr_q, rptr_q;
	logic [1:0] cnt_q;
	logic       do_wr, do_rd;

	assign room       = (cnt_q != 2'd2);
	assign head_valid = (cnt_q != 2'd0);
	assign head       = mem_q[rptr_q];
	assign do_wr      = wr && room;
	assign do_rd      = rd && head_valid;

	always_ff @(posedge clk) begin
		if (do_wr)
			mem_q[wptr_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			if (do_wr)
				wptr_q <= ~wptr_q;
			if (do_rd)
				rptr_q <= ~rptr_q;
			if (do_wr && !do_rd)
				cnt_q <= cnt_q + 2'd1;
			else if (do_rd && !do_wr)
				cnt_q <= cnt_q - 2'd1;
		end
	end

endmodule

// File: rtl/core/sst_back.sv
module sst_back import sst_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      head_valid,
	input  batch_t    head,
	output logic      head_pop,
	output logic      empty,
	output out_word_t result,
	input  logic      pop
);

	logic [RES_IDX_W-1:0] idx_q;
	out_word_t            out_q;
	logic                 vld_q;
	logic                 load, last_word;

	assign load      = head_valid && (!vld_q || pop);
	assign last_word = (RES_CNT_W'(idx_q) + 1'b1) >= head.n;
	assign head_pop  = load && last_word;
	assign empty     = !vld_q;
	assign result    = out_q;

	always_ff @(posedge clk) begin
		if (load)
			out_q <= head.res[idx_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			vld_q <= 1'b0;
		end else begin
			if (load)
				idx_q <= last_word ? '0 : idx_q + 1'b1;
			if (load)
				vld_q <= 1'b1;
			else if (pop)
				vld_q <= 1'b0;
		end
	end

endmodule

// File: rtl/core/script_source_tokenizer.sv
// source-text tokenizer, one source byte in, a stream of token bytes out
// input side is a queue: drive item and raise push; a word is taken at a clock
//   edge where push is high and full is low; item.at_end marks the end of the text
// result side is a queue too: while empty is low the oldest result word sits on
//   result; raising pop takes it at the next edge
// each result word is a token byte with its end-of-token flag, a finished word
//   with the saturated token count, or an error word with its code
// the front end classifies a byte in the cycle it is taken and writes all the
//   words it causes (up to four) as one entry of a two-entry queue
// the back end sends one word per cycle, while pop keeps up, through a single output register
// the words of a byte pass through the queue entry and then the output register
// throughput: a byte is taken every cycle while the queue has room; a byte that
//   causes more than one word holds the back end until each has gone out, so string
//   text, three words per byte, is paced by the one-word-per-cycle output register
// a stalled receiver fills the output register and then the queue, after which
//   full rises; nothing is lost, and words wait as long as needed
// reset (arst_n low) empties both queues and returns the scanner to plain text
module script_source_tokenizer import sst_pkg::*; #(
	parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  in_word_t  item,
	output logic      full,
	output logic      empty,
	output out_word_t result,
	input  logic      pop
);

	// front to queue
	logic   b_push;
	batch_t b_data;
	logic   q_room;

	// queue to back
	logic   head_valid;
	batch_t head;
	logic   head_pop;

	// classify and update the scanner state
	sst_front #(
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.item   (item),
		.full   (full),
		.q_room (q_room),
		.b_push (b_push),
		.b_data (b_data)
	);

	// decouples the scanner from a stalled receiver
	sst_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr         (b_push),
		.wdata      (b_data),
		.room       (q_room),
		.head_valid (head_valid),
		.head       (head),
		.rd         (head_pop)
	);

	// one word per cycle into the output register, while pop keeps up
	sst_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.head_pop   (head_pop),
		.empty      (empty),
		.result     (result),
		.pop        (pop)
	);

endmodule

// File: rtl/core/sst_checker.sv
`include "script_source_tokenizer_assert.svh"

module sst_checker import sst_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      full,
	input logic      empty,
	input out_word_t result,
	input logic      pop
);

	// a waiting word holds until taken
	`SST_ASSERT_NEXT(a_hold, !empty && !pop, !empty && $stable(result))
	// the input only backs up behind a waiting word
	`SST_ASSERT_NOW(a_full_busy, full, !empty)
	// only three kinds exist
	`SST_ASSERT_NOW(a_kind, !empty, result.out_kind != 2'd3)
	// token words carry no error code and no count
	`SST_ASSERT_NOW(a_tok_clean, !empty && result.out_kind == KIND_TOK,
		result.err_code == 2'd0 && result.token_count == 16'h0000)
	// other words carry no token byte
	`SST_ASSERT_NOW(a_other_clean, !empty && result.out_kind != KIND_TOK,
		result.tok_byte == 8'h00 && result.tok_last == 1'b0)

endmodule

bind script_source_tokenizer sst_checker u_sst_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.full   (full),
	.empty  (empty),
	.result (result),
	.pop    (pop)
);
